@@ rtl/sbrp_pkg.sv @@
// Shared types, constants and helpers for the single-bend route picker.
package sbrp_pkg;

  localparam int SLOT_W      = 6;
  localparam int IN_COORD_W  = 8;
  localparam int OUT_COORD_W = 8;
  localparam int LEN_W       = 9;
  localparam int CROSS_W     = 8;
  localparam int NCOUNT_W    = 7;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_IDX_W   = 1;

  // register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;

  // input word commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [SLOT_W-1:0]     node_slot;
    logic [IN_COORD_W-1:0] node_x;
    logic [IN_COORD_W-1:0] node_y;
    logic [SLOT_W-1:0]     from_node;
    logic [SLOT_W-1:0]     to_node;
  } in_word_t;

  typedef struct packed {
    logic                   bend_at_end_x;
    logic [CROSS_W-1:0]     crossings;
    logic [LEN_W-1:0]       route_length;
    logic                   x_forward;
    logic                   y_forward;
    logic [OUT_COORD_W-1:0] vert_rank;
    logic [OUT_COORD_W-1:0] vert_start;
    logic [OUT_COORD_W-1:0] vert_end;
    logic [OUT_COORD_W-1:0] horiz_rank;
    logic [OUT_COORD_W-1:0] horiz_start;
    logic [OUT_COORD_W-1:0] horiz_end;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_S,
    ST_RD_E,
    ST_LD_E,
    ST_RANGE,
    ST_WALK,
    ST_DONE
  } state_t;

  // narrow a zero-extended coordinate to the result field width
  function automatic logic [OUT_COORD_W-1:0] out_coord(input logic [15:0] v);
    return v[OUT_COORD_W-1:0];
  endfunction

  // narrow a zero-extended length to the result field width
  function automatic logic [LEN_W-1:0] out_len(input logic [16:0] v);
    return v[LEN_W-1:0];
  endfunction

endpackage

@@ rtl/single_bend_route_picker_unit.sv @@
// Top level of the single-bend route picker: sequencer, node store and ports.
//
// Use: words enter on the in_ channel (valid/stall) and results leave on the
// out_ channel. A load word (cmd = load) writes one node's coordinates into
// the node store in the cycle it is accepted and gives no result; the next
// word may follow at once. A query word (cmd = query) names a start and an
// end node and gives one result word: the picked L route, its crossing count,
// length, directions and both legs.
// A query steps RD_S, RD_E, LD_E, RANGE, WALK and DONE; DONE loads its
// result into the output register. The store's single read port fetches the
// two end nodes, then the walk reads N nodes, N being node_count clipped to
// MAX_NODES, one node per cycle into the shared leg compare unit.
// in_stall is high for the whole query; one query is in flight at a time.
// A finished result sits in the output register; a new word is accepted
// while it waits, but the next query holds in its last step until the
// receiver drops out_stall and the register frees.
// Reset clears the sequencer, the output valid and node_count. The node
// store is not cleared; query only nodes that were loaded. The user writes
// node_count on the APB-style cfg_ port while the block idles (unenforced).
module single_bend_route_picker_unit #(
  parameter int MAX_NODES  = 64,
  parameter int COORD_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sbrp_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sbrp_pkg::out_word_t                 out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [sbrp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [sbrp_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [sbrp_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int CMP_W  = (CNT_W > sbrp_pkg::NCOUNT_W) ? CNT_W : sbrp_pkg::NCOUNT_W;
  localparam int RW     = (CNT_W > sbrp_pkg::SLOT_W) ? CNT_W : sbrp_pkg::SLOT_W;
  localparam int SLOT_W = sbrp_pkg::SLOT_W;
  localparam int NC_W   = sbrp_pkg::NCOUNT_W;

  // configuration
  logic [NC_W-1:0] node_count_r;
  logic            cfg_wr;
  logic            cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_hit    = (cfg_paddr[sbrp_pkg::CFG_ADDR_W-1:2] == sbrp_pkg::REG_NODE_COUNT);
  assign cfg_prdata = cfg_hit ? sbrp_pkg::CFG_DATA_W'(node_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
    end else if (cfg_wr && cfg_hit) begin
      node_count_r <= cfg_pwdata[NC_W-1:0];
    end
  end

  // sequencer state
  sbrp_pkg::state_t state_r, state_nxt;

  logic                  in_acc;
  logic                  out_free;
  logic [SLOT_W-1:0]     s_r, e_r;
  logic [CNT_W-1:0]      lim_r, lim_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      ridx_r;
  logic                  rvld_r, rvld_nxt;
  logic                  issue;
  logic                  hit_clr;
  logic [COORD_BITS-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [COORD_BITS-1:0] xlo_r, xhi_r, ylo_r, yhi_r;
  logic                  s_ok, e_ok;
  logic                  skip;
  logic [CMP_W-1:0]      nc_ext;

  // node store port signals
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_raddr;
  logic [2*COORD_BITS-1:0]   ram_rdata;
  logic [COORD_BITS-1:0]     rd_x, rd_y;

  // hit counts and result
  logic [sbrp_pkg::CROSS_W-1:0] cnt_a, cnt_b;
  logic                         pick_b;
  logic [COORD_BITS:0]          len;
  logic                         out_valid_r, out_valid_nxt;
  sbrp_pkg::out_word_t          out_data_r, out_data_nxt;

  assign in_stall = (state_r != sbrp_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign rd_x = ram_rdata[2*COORD_BITS-1:COORD_BITS];
  assign rd_y = ram_rdata[COORD_BITS-1:0];

  // out-of-range query indexes read as the origin
  assign s_ok = RW'(s_r) < RW'(MAX_NODES);
  assign e_ok = RW'(e_r) < RW'(MAX_NODES);
  assign skip = (RW'(ridx_r) == RW'(s_r)) || (RW'(ridx_r) == RW'(e_r));

  // loads whose slot lies beyond the store are dropped
  assign ram_we = in_acc && (in_data.cmd == sbrp_pkg::CMD_LOAD) &&
                  (RW'(in_data.node_slot) < RW'(MAX_NODES));

  assign nc_ext  = CMP_W'(node_count_r);
  assign lim_nxt = (nc_ext > CMP_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(nc_ext);
  assign issue   = (state_r == sbrp_pkg::ST_WALK) && (idx_r < lim_r);

  assign pick_b = cnt_b < cnt_a;
  assign len    = ((COORD_BITS+1)'(xhi_r) - (COORD_BITS+1)'(xlo_r)) +
                  ((COORD_BITS+1)'(yhi_r) - (COORD_BITS+1)'(ylo_r));

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    hit_clr       = 1'b0;
    ram_raddr     = idx_r[IDX_W-1:0];
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rvld_nxt      = issue;
    unique case (state_r)
      sbrp_pkg::ST_IDLE: begin
        if (in_acc && (in_data.cmd == sbrp_pkg::CMD_QUERY)) begin
          state_nxt = sbrp_pkg::ST_RD_S;
        end
      end
      sbrp_pkg::ST_RD_S: begin
        ram_raddr = IDX_W'(s_r);
        state_nxt = sbrp_pkg::ST_RD_E;
      end
      sbrp_pkg::ST_RD_E: begin
        ram_raddr = IDX_W'(e_r);
        state_nxt = sbrp_pkg::ST_LD_E;
      end
      sbrp_pkg::ST_LD_E: begin
        state_nxt = sbrp_pkg::ST_RANGE;
      end
      sbrp_pkg::ST_RANGE: begin
        hit_clr   = 1'b1;
        idx_nxt   = '0;
        state_nxt = sbrp_pkg::ST_WALK;
      end
      sbrp_pkg::ST_WALK: begin
        // advance one node per cycle; the last read lands as we leave
        if (issue) begin
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          state_nxt = sbrp_pkg::ST_DONE;
        end
      end
      sbrp_pkg::ST_DONE: begin
        // hold until the output register frees
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.bend_at_end_x = pick_b;
          out_data_nxt.crossings     = pick_b ? cnt_b : cnt_a;
          out_data_nxt.route_length  = sbrp_pkg::out_len(17'(len));
          out_data_nxt.x_forward     = sx_r < ex_r;
          out_data_nxt.y_forward     = sy_r < ey_r;
          out_data_nxt.vert_rank     = sbrp_pkg::out_coord(16'(pick_b ? ex_r : sx_r));
          out_data_nxt.vert_start    = sbrp_pkg::out_coord(16'(ylo_r));
          out_data_nxt.vert_end      = sbrp_pkg::out_coord(16'(yhi_r));
          out_data_nxt.horiz_rank    = sbrp_pkg::out_coord(16'(pick_b ? sy_r : ey_r));
          out_data_nxt.horiz_start   = sbrp_pkg::out_coord(16'(xlo_r));
          out_data_nxt.horiz_end     = sbrp_pkg::out_coord(16'(xhi_r));
          state_nxt                  = sbrp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sbrp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbrp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      rvld_r      <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rvld_r      <= rvld_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    ridx_r     <= idx_r[IDX_W-1:0];
    if (in_acc) begin
      s_r   <= in_data.from_node;
      e_r   <= in_data.to_node;
      lim_r <= lim_nxt;
    end
    if (state_r == sbrp_pkg::ST_RD_E) begin
      sx_r <= s_ok ? rd_x : '0;
      sy_r <= s_ok ? rd_y : '0;
    end
    if (state_r == sbrp_pkg::ST_LD_E) begin
      ex_r <= e_ok ? rd_x : '0;
      ey_r <= e_ok ? rd_y : '0;
    end
    if (state_r == sbrp_pkg::ST_RANGE) begin
      xlo_r <= (sx_r < ex_r) ? sx_r : ex_r;
      xhi_r <= (sx_r < ex_r) ? ex_r : sx_r;
      ylo_r <= (sy_r < ey_r) ? sy_r : ey_r;
      yhi_r <= (sy_r < ey_r) ? ey_r : sy_r;
    end
  end

  sbrp_ram #(
    .WIDTH (2*COORD_BITS),
    .DEPTH (MAX_NODES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(in_data.node_slot)),
    .wdata ({COORD_BITS'(in_data.node_x), COORD_BITS'(in_data.node_y)}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // route A: vertical leg at start x, horizontal at end y; route B the mirror
  sbrp_hit_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_hit (
    .clk    (clk),
    .clr    (hit_clr),
    .vld    (rvld_r),
    .skip   (skip),
    .node_x (rd_x),
    .node_y (rd_y),
    .vr_a   (sx_r),
    .hr_a   (ey_r),
    .vr_b   (ex_r),
    .hr_b   (sy_r),
    .xlo    (xlo_r),
    .xhi    (xhi_r),
    .ylo    (ylo_r),
    .yhi    (yhi_r),
    .cnt_a  (cnt_a),
    .cnt_b  (cnt_b)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/sbrp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sbrp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/sbrp_hit_unit.sv @@
// Shared leg compare unit: tests one node against both routes and counts hits.
module sbrp_hit_unit #(
  parameter int COORD_BITS = 8
) (
  input  logic                        clk,
  input  logic                        clr,
  input  logic                        vld,
  input  logic                        skip,
  input  logic [COORD_BITS-1:0]       node_x,
  input  logic [COORD_BITS-1:0]       node_y,
  input  logic [COORD_BITS-1:0]       vr_a,
  input  logic [COORD_BITS-1:0]       hr_a,
  input  logic [COORD_BITS-1:0]       vr_b,
  input  logic [COORD_BITS-1:0]       hr_b,
  input  logic [COORD_BITS-1:0]       xlo,
  input  logic [COORD_BITS-1:0]       xhi,
  input  logic [COORD_BITS-1:0]       ylo,
  input  logic [COORD_BITS-1:0]       yhi,
  output logic [sbrp_pkg::CROSS_W-1:0] cnt_a,
  output logic [sbrp_pkg::CROSS_W-1:0] cnt_b
);

  localparam int CW = sbrp_pkg::CROSS_W;

  logic          x_in, y_in;
  logic [1:0]    inc_a, inc_b;
  logic [CW:0]   sum_a, sum_b;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;

  always_comb begin
    x_in  = (xlo <= node_x) && (node_x <= xhi);
    y_in  = (ylo <= node_y) && (node_y <= yhi);
    inc_a = 2'({1'b0, (node_x == vr_a) && y_in}) + 2'({1'b0, (node_y == hr_a) && x_in});
    inc_b = 2'({1'b0, (node_x == vr_b) && y_in}) + 2'({1'b0, (node_y == hr_b) && x_in});
    sum_a = {1'b0, cnt_a_r} + (CW+1)'(inc_a);
    sum_b = {1'b0, cnt_b_r} + (CW+1)'(inc_b);
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    if (clr) begin
      cnt_a_nxt = '0;
      cnt_b_nxt = '0;
    end else if (vld && !skip) begin
      // saturate at all ones
      cnt_a_nxt = sum_a[CW] ? '1 : sum_a[CW-1:0];
      cnt_b_nxt = sum_b[CW] ? '1 : sum_b[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    cnt_a_r <= cnt_a_nxt;
    cnt_b_r <= cnt_b_nxt;
  end

  assign cnt_a = cnt_a_r;
  assign cnt_b = cnt_b_r;

endmodule
